// ===== rtl/core/afc_pkg.sv =====
// Shared types, constants and the exponent table for the feed-forward compressor.
// Depends on nothing; every other file in rtl/core imports it.
package afc_pkg;

    localparam int SAMPLE_WIDTH = 24;

    // Level offset added to the magnitude so that the logarithm never sees zero.
    localparam longint EPS_RAW = ((64'd1 << (SAMPLE_WIDTH - 1)) + 64'd50000) / 64'd100000;
    localparam logic [SAMPLE_WIDTH-1:0] EPS = (EPS_RAW == 0) ? SAMPLE_WIDTH'(1)
                                                             : SAMPLE_WIDTH'(EPS_RAW);

    localparam logic [20:0] LG_TOP    = 21'((SAMPLE_WIDTH - 1) * 65536);
    localparam logic [18:0] LOG_TO_DB = 19'd394566;
    localparam logic [21:0] DB_TO_LOG = 22'd2786635;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [16:0] MIN_GAIN_DB = 17'd25600;
    localparam logic [16:0] ENV_ONE   = 17'h1_0000;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_RATIO     = 3'd1,
        REG_ATTACK    = 3'd2,
        REG_RELEASE   = 3'd3,
        REG_MAKEUP    = 3'd4
    } afc_reg_idx_t;

    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic        [15:0] ratio_slope;
        logic        [16:0] attack_coeff;
        logic        [16:0] release_coeff;
        logic signed [13:0] makeup_db;
    } afc_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] audio_out;
        logic        [16:0]             gain_now;
    } afc_res_t;

    typedef logic [30:0] pow_tab_t [0:16];

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] bt;
        v    = v_in;
        root = '0;
        bt   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= root + bt) begin
                v    = v - (root + bt);
                root = (root >> 1) + bt;
            end else begin
                root = root >> 1;
            end
            bt = bt >> 2;
        end
        return root;
    endfunction

    // Entry k is 2^(-2^-k) in Q30, each one the square root of the one before.
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t    t;
        logic [63:0] cur;
        cur  = 64'd1 << 29;
        t[0] = cur[30:0];
        for (int k = 1; k < 17; k++) begin
            cur  = isqrt64(cur << 30);
            t[k] = cur[30:0];
        end
        return t;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

// ===== rtl/core/audio_feedforward_compressor_top.sv =====
// Channel       | Signals                                   | Transfer
// input sample  | s_valid, s_ready, s_audio_in              | valid and ready both high
// result        | m_valid, m_ready, m_audio_out, m_gain_now | valid and ready both high
// configuration | cfg_we, cfg_idx, cfg_wdata                | write enable high
//
// Each sample is computed through the single shared multiplier before the next is accepted:
// 16 squarings for the logarithm and two 16-step exponent chains (gain target and
// makeup), plus the envelope and output products.
// Synchronous active-low reset restores the configuration defaults, clears the output valid flag and
// the sequencer state, and sets the envelope to unity. A finished result waits in the output
// register; the sequencer holds its next result until that register is free, and accepts no new request meanwhile.
module audio_feedforward_compressor_top
    import afc_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_audio_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_audio_out,
    output logic        [16:0]             m_gain_now,
    input  logic                           cfg_we,
    input  logic        [2:0]              cfg_idx,
    input  logic        [16:0]             cfg_wdata
);

    afc_cfg_t cfg_reg, cfg_next;
    afc_res_t res, res_out_reg, res_out_next;
    logic     out_valid_reg, out_valid_next;
    logic     core_idle, res_valid, res_ready;

    afc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && s_ready),
        .sample    (s_audio_in),
        .idle      (core_idle),
        .cfg       (cfg_reg),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    assign s_ready     = core_idle;
    assign res_ready   = !out_valid_reg || m_ready;
    assign m_valid     = out_valid_reg;
    assign m_audio_out = res_out_reg.audio_out;
    assign m_gain_now  = res_out_reg.gain_now;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx)
                REG_THRESHOLD: cfg_next.threshold_db  = $signed(cfg_wdata[15:0]);
                REG_RATIO:     cfg_next.ratio_slope   = cfg_wdata[15:0];
                REG_ATTACK:    cfg_next.attack_coeff  = cfg_wdata;
                REG_RELEASE:   cfg_next.release_coeff = cfg_wdata;
                REG_MAKEUP:    cfg_next.makeup_db     = $signed(cfg_wdata[13:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res_out_next   = res_out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready) begin
            res_out_next   = res;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_db  <= -16'sd5120;
            cfg_reg.ratio_slope   <= 16'd49152;
            cfg_reg.attack_coeff  <= 17'd136;
            cfg_reg.release_coeff <= 17'd14;
            cfg_reg.makeup_db     <= 14'sd0;
            out_valid_reg         <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
        res_out_reg <= res_out_next;
    end

endmodule

// ===== rtl/core/afc_mul.sv =====
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on afc_pkg only through the common import convention.
module afc_mul
    import afc_pkg::*;
(
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    assign prod_next = 64'(op_a) * 64'(op_b);
    assign prod      = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// ===== rtl/core/afc_core.sv =====
// Sequencer and datapath registers of the compressor: level, gain computer,
// envelope and output scaling, all driven through the shared multiplier afc_mul.
module afc_core
    import afc_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           idle,
    input  afc_cfg_t                       cfg,
    input  logic                           res_ready,
    output logic                           res_valid,
    output afc_res_t                       res
);

    localparam int SW = SAMPLE_WIDTH;
    localparam logic [47:0] FS_POS = 48'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic [47:0] FS_NEG = 48'(64'd1 << (SW - 1));

    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_LOG_ISSUE, S_LOG, S_LVL_ISSUE, S_LVL, S_RED, S_TGT_EXP,
        S_EXP, S_EXP_END, S_MK_ISSUE, S_MK_EXP, S_ENV_A, S_ENV_B, S_ENV_C,
        S_OUT_A, S_OUT_B, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [SW-1:0]   mag_reg, mag_next;
    logic            neg_reg, neg_next;
    logic [SW-1:0]   a_reg, a_next;
    logic [4:0]      pos_reg, pos_next;
    logic [30:0]     m_reg, m_next;
    logic [15:0]     lg_frac_reg, lg_frac_next;
    logic            zero_tgt_reg, zero_tgt_next;
    logic [15:0]     f_reg, f_next;
    logic [5:0]      r_reg, r_next;
    logic            mk_phase_reg, mk_phase_next;
    logic [16:0]     target_reg, target_next;
    logic [22:0]     makeup_reg, makeup_next;
    logic [16:0]     env_reg, env_next;
    logic [16:0]     c_reg, c_next;
    logic [33:0]     acc_reg, acc_next;
    logic [SW-1:0]   out_reg, out_next;

    logic [31:0]     op_a, op_b;
    logic [63:0]     prod;
    logic [63:0]     t15, t23, t29;
    logic [30:0]     p_round;
    logic [31:0]     mq;
    logic            sq_bit;
    logic [30:0]     m_new, m_init;
    logic [20:0]     lg, d_val;
    logic [15:0]     lvl_mag;
    logic signed [16:0] lvl;
    logic signed [17:0] over;
    logic [16:0]     over_pos, red;
    logic [21:0]     e_val;
    logic [13:0]     mk_mag;
    logic [16:0]     c_sel, c_sat;
    logic [63:0]     env_sum;
    logic [16:0]     env_new;
    logic [SW-1:0]   ym;
    logic [47:0]     ym2, ym2_sat;
    logic [30:0]     tsel, p_in;
    logic [63:0]     rs_sum, rs_val;

    afc_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign t15     = prod + 64'd32768;
    assign t23     = prod + (64'd1 << 23);
    assign t29     = prod + (64'd1 << 29);
    assign p_round = t29[60:30];

    // One squaring step of the logarithm: a square of two or more yields a one bit.
    assign mq     = prod[61:30];
    assign sq_bit = mq[31];
    assign m_new  = sq_bit ? mq[31:1] : mq[30:0];
    assign m_init = 31'({a_reg, 31'd0} >> SW);

    assign lg      = {pos_reg, lg_frac_reg};
    assign d_val   = (lg >= LG_TOP) ? 21'd0 : (LG_TOP - lg);
    assign lvl_mag = t23[39:24];
    assign lvl     = -$signed({1'b0, lvl_mag});
    assign over    = 18'(lvl) - 18'(cfg.threshold_db);
    assign over_pos = (lvl > cfg.threshold_db) ? over[16:0] : 17'd0;
    assign red     = t15[32:16];
    assign e_val   = t15[37:16];
    assign mk_mag  = cfg.makeup_db[13] ? 14'(-cfg.makeup_db) : cfg.makeup_db;

    assign c_sel   = (target_reg < env_reg) ? cfg.attack_coeff : cfg.release_coeff;
    assign c_sat   = (c_sel > ENV_ONE) ? ENV_ONE : c_sel;
    assign env_sum = 64'(acc_reg) + prod + 64'd32768;
    assign env_new = env_sum[32:16];
    assign ym      = t15[SW+15:16];
    assign ym2     = t15[63:16];
    assign ym2_sat = neg_reg ? ((ym2 > FS_NEG) ? FS_NEG : ym2)
                             : ((ym2 > FS_POS) ? FS_POS : ym2);

    assign p_in   = (cnt_reg == 4'd0) ? Q30_ONE : p_round;
    assign tsel   = f_reg[~cnt_reg] ? POW_TAB[5'(cnt_reg) + 5'd1] : Q30_ONE;
    assign rs_sum = {33'd0, p_round} + (64'd1 << (r_reg - 6'd1));
    assign rs_val = rs_sum >> r_reg;

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.audio_out = $signed(out_reg);
    assign res.gain_now  = env_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        a_next        = a_reg;
        pos_next      = pos_reg;
        m_next        = m_reg;
        lg_frac_next  = lg_frac_reg;
        zero_tgt_next = zero_tgt_reg;
        f_next        = f_reg;
        r_next        = r_reg;
        mk_phase_next = mk_phase_reg;
        target_next   = target_reg;
        makeup_next   = makeup_reg;
        env_next      = env_reg;
        c_next        = c_reg;
        acc_next      = acc_reg;
        out_next      = out_reg;
        op_a          = 32'd0;
        op_b          = 32'd0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    neg_next   = sample[SW-1];
                    mag_next   = sample[SW-1] ? SW'(-sample) : SW'(sample);
                    a_next     = (sample[SW-1] ? SW'(-sample) : SW'(sample)) + EPS;
                    pos_next   = 5'(SW - 1);
                    cnt_next   = 4'd0;
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                // Binary search for the leading one: 16, 8, 4, 2 and 1 bit steps.
                case (cnt_reg)
                    4'd0: begin
                        if (a_reg[SW-1 -: 16] == '0) begin
                            a_next = a_reg << 16; pos_next = pos_reg - 5'd16;
                        end
                    end
                    4'd1: begin
                        if (a_reg[SW-1 -: 8] == '0) begin
                            a_next = a_reg << 8; pos_next = pos_reg - 5'd8;
                        end
                    end
                    4'd2: begin
                        if (a_reg[SW-1 -: 4] == '0) begin
                            a_next = a_reg << 4; pos_next = pos_reg - 5'd4;
                        end
                    end
                    4'd3: begin
                        if (a_reg[SW-1 -: 2] == '0) begin
                            a_next = a_reg << 2; pos_next = pos_reg - 5'd2;
                        end
                    end
                    default: begin
                        if (!a_reg[SW-1]) begin
                            a_next = a_reg << 1; pos_next = pos_reg - 5'd1;
                        end
                    end
                endcase
                if (cnt_reg == 4'd4) begin
                    cnt_next   = 4'd0;
                    state_next = S_LOG_ISSUE;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_LOG_ISSUE: begin
                m_next       = m_init;
                lg_frac_next = '0;
                op_a         = 32'(m_init);
                op_b         = 32'(m_init);
                cnt_next     = 4'd0;
                state_next   = S_LOG;
            end
            S_LOG: begin
                m_next                = m_new;
                lg_frac_next[~cnt_reg] = sq_bit;
                op_a                  = 32'(m_new);
                op_b                  = 32'(m_new);
                cnt_next              = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = S_LVL_ISSUE;
                end
            end
            S_LVL_ISSUE: begin
                op_a       = 32'(d_val);
                op_b       = 32'(LOG_TO_DB);
                state_next = S_LVL;
            end
            S_LVL: begin
                op_a       = 32'(over_pos);
                op_b       = 32'(cfg.ratio_slope);
                state_next = S_RED;
            end
            S_RED: begin
                zero_tgt_next = (red >= MIN_GAIN_DB);
                op_a          = 32'(red);
                op_b          = 32'(DB_TO_LOG);
                state_next    = S_TGT_EXP;
            end
            S_TGT_EXP: begin
                f_next        = e_val[15:0];
                r_next        = 6'd14 + e_val[21:16];
                mk_phase_next = 1'b0;
                cnt_next      = 4'd0;
                state_next    = S_EXP;
            end
            S_EXP: begin
                // Multiplying by unity where the exponent bit is clear keeps the
                // product chain uniform.
                op_a     = 32'(p_in);
                op_b     = 32'(tsel);
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = S_EXP_END;
                end
            end
            S_EXP_END: begin
                if (mk_phase_reg) begin
                    makeup_next = rs_val[22:0];
                    state_next  = S_ENV_A;
                end else begin
                    target_next = zero_tgt_reg ? 17'd0 : rs_val[16:0];
                    state_next  = S_MK_ISSUE;
                end
            end
            S_MK_ISSUE: begin
                op_a       = 32'(mk_mag);
                op_b       = 32'(DB_TO_LOG);
                state_next = S_MK_EXP;
            end
            S_MK_EXP: begin
                // A positive exponent n+f is taken as 2^(n+1) times 2^-(1-f).
                if (cfg.makeup_db[13]) begin
                    f_next = e_val[15:0];
                    r_next = 6'd14 + e_val[21:16];
                end else if (e_val[15:0] == 16'd0) begin
                    f_next = 16'd0;
                    r_next = 6'd14 - e_val[21:16];
                end else begin
                    f_next = 16'(17'h1_0000 - 17'(e_val[15:0]));
                    r_next = 6'd13 - e_val[21:16];
                end
                mk_phase_next = 1'b1;
                cnt_next      = 4'd0;
                state_next    = S_EXP;
            end
            S_ENV_A: begin
                c_next     = c_sat;
                op_a       = 32'(env_reg);
                op_b       = 32'(ENV_ONE - c_sat);
                state_next = S_ENV_B;
            end
            S_ENV_B: begin
                acc_next   = prod[33:0];
                op_a       = 32'(target_reg);
                op_b       = 32'(c_reg);
                state_next = S_ENV_C;
            end
            S_ENV_C: begin
                env_next   = env_new;
                op_a       = 32'(mag_reg);
                op_b       = 32'(env_new);
                state_next = S_OUT_A;
            end
            S_OUT_A: begin
                op_a       = 32'(ym);
                op_b       = 32'(makeup_reg);
                state_next = S_OUT_B;
            end
            S_OUT_B: begin
                out_next   = neg_reg ? SW'(-ym2_sat) : SW'(ym2_sat);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= 4'd0;
            env_reg   <= ENV_ONE;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            env_reg   <= env_next;
        end
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        a_reg        <= a_next;
        pos_reg      <= pos_next;
        m_reg        <= m_next;
        lg_frac_reg  <= lg_frac_next;
        zero_tgt_reg <= zero_tgt_next;
        f_reg        <= f_next;
        r_reg        <= r_next;
        mk_phase_reg <= mk_phase_next;
        target_reg   <= target_next;
        makeup_reg   <= makeup_next;
        c_reg        <= c_next;
        acc_reg      <= acc_next;
        out_reg      <= out_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (state_reg == S_NORM))
        else $error("Accepted request did not start the level measurement");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOG_ISSUE) |-> a_reg[SW-1])
        else $error("Magnitude not normalised before the logarithm");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOG) |-> m_reg[30])
        else $error("Logarithm mantissa left the range one to two");

    assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg <= ENV_ONE)
        else $error("Envelope gain exceeded unity");

endmodule
